@@ rtl/core/vector3_normalize_core_assert.svh @@
// ----------------------------------------------------------------------------
// vector3_normalize_core assertion macros
// Property shorthands used by the normalizer pipeline.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZE_CORE_ASSERT_SVH
`define VECTOR3_NORMALIZE_CORE_ASSERT_SVH

// same-cycle implication
`define VN3_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VN3_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/vn3_pkg.sv @@
// ----------------------------------------------------------------------------
// vn3_pkg
// Widths and lane type shared by the vector normalizer pipeline.
// ----------------------------------------------------------------------------
package vn3_pkg;

   localparam int unsigned CW  = 24;   // input component width
   localparam int unsigned MW  = 24;   // magnitude width (up to 2^23)
   localparam int unsigned SQW = 47;   // square of a magnitude
   localparam int unsigned SW  = 48;   // squared length
   localparam int unsigned QW  = 15;   // quotient bits, up to 16384
   localparam int unsigned OW  = 16;   // output component width
   localparam int unsigned FSH = 30;   // (2 * 2^14)^2 as a shift
   localparam int unsigned RW  = 82;   // residual width, signed
   localparam int unsigned PW  = 64;   // running u*S width, signed

   typedef struct packed {
      logic signed [RW-1:0] r;
      logic signed [PW-1:0] p;
      logic [QW-1:0]        t;
      logic                 neg;
   } lane_type;

endpackage

@@ rtl/core/vector3_normalize_core.sv @@
// Stages in order: magnitude, square, residual seed, quotient bits, sign.
// Throughput: one vector per cycle while rsp_tready is high; each of the 15
// quotient bits has its own stage per component, and the squares use three
// 24x24 multipliers. A stall holds full stages back to the first empty one.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// vector3_normalize_core
// Pipelined 3D vector normalizer, Q12.12 in, rounded Q2.14 out.
// ----------------------------------------------------------------------------
`include "vector3_normalize_core_assert.svh"

module vector3_normalize_core
   import vn3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // vec_x, vec_y, vec_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // unit_x, unit_y, unit_z
   output logic        rsp_tuser    // zero_length
);

   localparam int unsigned NST = QW + 4;

   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;
   logic [NST:0]   ready;

   logic [MW-1:0]  mag_ff [3];
   logic [2:0]     neg1_ff;
   logic [SQW-1:0] sq_ff [3];
   logic [2:0]     neg2_ff;

   lane_type       lane_pipe [QW+1][3];
   lane_type       lane_in   [3];
   logic [SW-1:0]  s_pipe    [QW];
   logic [QW:0]    zero_pipe;
   logic [SW-1:0]  s_in;

   logic [OW-1:0]  unit_ff [3];
   logic           zero_ff;

   always_comb begin
      ready[NST] = rsp_tready;
      for (int i = NST - 1; i >= 0; i--) begin
         ready[i] = ~valid_ff[i] | ready[i+1];
      end
      valid_in = {valid_ff[NST-2:0], req_tvalid};
   end

   assign req_tready = ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (ready[i]) valid_ff[i] <= valid_in[i];
         end
      end
   end

   // magnitudes
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         for (int c = 0; c < 3; c++) begin
            neg1_ff[c] <= req_tdata[c*CW + CW - 1];
            mag_ff[c]  <= req_tdata[c*CW + CW - 1]
                          ? MW'(-req_tdata[c*CW +: CW]) : req_tdata[c*CW +: CW];
         end
      end
   end

   // squares
   always_ff @(posedge clock) begin
      if (ready[1]) begin
         for (int c = 0; c < 3; c++) begin
            sq_ff[c] <= SQW'(mag_ff[c] * mag_ff[c]);
         end
         neg2_ff <= neg1_ff;
      end
   end

   // squared length and residual seed for t = 0 (u = -1)
   always_comb begin
      s_in = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      for (int c = 0; c < 3; c++) begin
         lane_in[c].r   = $signed(RW'(sq_ff[c]) << FSH) - $signed(RW'(s_in));
         lane_in[c].p   = -$signed(PW'(s_in));
         lane_in[c].t   = '0;
         lane_in[c].neg = neg2_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         for (int c = 0; c < 3; c++) lane_pipe[0][c] <= lane_in[c];
         s_pipe[0]    <= s_in;
         zero_pipe[0] <= (s_in == '0);
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_bit
      for (genvar c = 0; c < 3; c++) begin : g_lane
         vn3_step #(.BIT(QW - 1 - j)) u_step (
            .clock   (clock),
            .en      (ready[j+3]),
            .s       (s_pipe[j]),
            .lane_in (lane_pipe[j][c]),
            .lane_ff (lane_pipe[j+1][c])
         );
      end
      always_ff @(posedge clock) begin
         if (ready[j+3]) begin
            zero_pipe[j+1] <= zero_pipe[j];
         end
      end
      if (j < QW - 1) begin : g_s
         always_ff @(posedge clock) begin
            if (ready[j+3]) begin
               s_pipe[j+1] <= s_pipe[j];
            end
         end
      end
   end

   // apply sign, force zero for a zero vector
   always_ff @(posedge clock) begin
      if (ready[NST-1]) begin
         for (int c = 0; c < 3; c++) begin
            if (zero_pipe[QW]) begin
               unit_ff[c] <= '0;
            end else begin
               unit_ff[c] <= lane_pipe[QW][c].neg ? OW'(-OW'(lane_pipe[QW][c].t))
                                                  : OW'(lane_pipe[QW][c].t);
            end
         end
         zero_ff <= zero_pipe[QW];
      end
   end

   assign rsp_tvalid = valid_ff[NST-1];
   assign rsp_tdata  = {unit_ff[2], unit_ff[1], unit_ff[0]};
   assign rsp_tuser  = zero_ff;

   `VN3_ASSERT_NOW(a_zero_out, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "zero vector gave nonzero output")
   `VN3_ASSERT_NOW(a_range_x, clock, reset, rsp_tvalid, ($signed(rsp_tdata[15:0]) <= 16'sd16384) && ($signed(rsp_tdata[15:0]) >= -16'sd16384), "unit_x out of range")
   `VN3_ASSERT_NEXT(a_enter, clock, reset, req_tvalid && req_tready, valid_ff[0], "accepted beat not captured")
   `VN3_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled output changed")

endmodule

@@ rtl/core/vn3_step.sv @@
// ----------------------------------------------------------------------------
// vn3_step
// One quotient bit of the rounded scaled division c * 2^14 / sqrt(S).
// ----------------------------------------------------------------------------
module vn3_step
   import vn3_pkg::*;
#(
   parameter int unsigned BIT = 0
) (
   input  logic          clock,
   input  logic          en,
   input  logic [SW-1:0] s,
   input  lane_type      lane_in,
   output lane_type      lane_ff
);

   localparam int unsigned SH_P = BIT + 2;
   localparam int unsigned SH_S = 2 * BIT + 2;
   localparam int unsigned SH_U = BIT + 1;

   logic signed [RW-1:0] inc;
   logic signed [RW-1:0] diff;
   logic signed [PW-1:0] p_add;
   logic                 take;
   lane_type             lane_in_next;

   always_comb begin
      inc   = (RW'(lane_in.p) <<< SH_P) + $signed(RW'(s) << SH_S);
      diff  = lane_in.r - inc;
      take  = ~diff[RW-1];
      p_add = $signed(PW'(s) << SH_U);
      lane_in_next     = lane_in;
      if (take) begin
         lane_in_next.r = diff;
         lane_in_next.p = lane_in.p + p_add;
         lane_in_next.t = lane_in.t | (QW'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in_next;
      end
   end

endmodule
